FILE: rtl/core/marching_squares_tracer_assert.svh
// Assertion macros for the contour tracer, clocked on clk, quiet during rst.
`ifndef MARCHING_SQUARES_TRACER_ASSERT_SVH
`define MARCHING_SQUARES_TRACER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mst_pkg.sv
// Shared types, codes and lookup functions for the marching squares tracer.
package mst_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int IO_BITS            = 16;
  localparam int WIN_BITS           = 15;

  localparam logic [WIN_BITS-1:0] WIN_WIDTH_RESET  = 15'd640;
  localparam logic [WIN_BITS-1:0] WIN_HEIGHT_RESET = 15'd480;

  // Item function codes
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_WIN_WIDTH  = 1'b0;
  localparam logic CFG_WIN_HEIGHT = 1'b1;

  // Corner masks: bit3 top-left, bit2 top-right, bit1 bottom-left, bit0 bottom-right
  localparam logic [3:0] CORNERS_TOP    = 4'hC;
  localparam logic [3:0] CORNERS_BOTTOM = 4'h3;
  localparam logic [3:0] CORNERS_LEFT   = 4'hA;
  localparam logic [3:0] CORNERS_RIGHT  = 4'h5;
  localparam logic [3:0] CORNERS_ALL    = 4'hF;
  localparam logic [3:0] CORNERS_NONE   = 4'h0;

  typedef enum logic [1:0] {
    DIR_UP = 2'd0,
    DIR_LT = 2'd1,
    DIR_DN = 2'd2,
    DIR_RT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    EMIT_NONE   = 2'd0,
    EMIT_MOVE   = 2'd1,
    EMIT_LINE   = 2'd2,
    EMIT_CLOSED = 2'd3
  } emit_t;

  typedef struct packed {
    logic [3:0] known;
    logic [3:0] unknown;
    logic       hit;
    logic       went_in;
    logic       closed;
  } flags_t;

  typedef struct packed {
    emit_t               kind;
    logic [IO_BITS-1:0]  vertex_x;
    logic [IO_BITS-1:0]  vertex_y;
    logic [IO_BITS-1:0]  next_x;
    logic [IO_BITS-1:0]  next_y;
    logic [3:0]          need_mask;
    logic                entered_map;
  } result_t;

  // Walk direction for each corner pattern
  function automatic dir_t step_dir(input logic [3:0] corners);
    dir_t d;
    case (corners)
      4'd0:    d = DIR_RT;
      4'd1:    d = DIR_DN;
      4'd2:    d = DIR_LT;
      4'd3:    d = DIR_LT;
      4'd4:    d = DIR_RT;
      4'd5:    d = DIR_DN;
      4'd6:    d = DIR_LT;
      4'd7:    d = DIR_LT;
      4'd8:    d = DIR_UP;
      4'd9:    d = DIR_UP;
      4'd10:   d = DIR_UP;
      4'd11:   d = DIR_UP;
      4'd12:   d = DIR_RT;
      4'd13:   d = DIR_DN;
      4'd14:   d = DIR_RT;
      default: d = DIR_RT;
    endcase
    return d;
  endfunction

  // Corners shared with the neighbor square, moved to their place there
  function automatic logic [3:0] slide(input dir_t d, input logic [3:0] v);
    logic [3:0] r;
    case (d)
      DIR_UP:  r = (v & CORNERS_TOP) >> 2;
      DIR_DN:  r = (v & CORNERS_BOTTOM) << 2;
      DIR_LT:  r = (v & CORNERS_LEFT) >> 1;
      default: r = (v & CORNERS_RIGHT) << 1;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/mst_step.sv
// One tracing step: next trace state and result for one item.
module mst_step import mst_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                  func,
  input  logic [IO_BITS-1:0]    begin_x,
  input  logic [IO_BITS-1:0]    begin_y,
  input  logic [3:0]            corner_bits,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [COORD_BITS-1:0] first_x,
  input  logic [COORD_BITS-1:0] first_y,
  input  flags_t                flags,
  input  logic [WIN_BITS-1:0]   map_width,
  input  logic [WIN_BITS-1:0]   map_height,
  output logic [COORD_BITS-1:0] pos_x_next,
  output logic [COORD_BITS-1:0] pos_y_next,
  output logic [COORD_BITS-1:0] first_x_next,
  output logic [COORD_BITS-1:0] first_y_next,
  output flags_t                flags_next,
  output result_t               result
);

  localparam int CmpBits = (COORD_BITS > WIN_BITS) ? COORD_BITS : WIN_BITS;

  logic [3:0]        corners;
  logic              on_boundary;
  logic              in_window;
  logic              went_in_new;
  logic              at_first;
  dir_t              dir;
  logic [IO_BITS-1:0] cur_x16;
  logic [IO_BITS-1:0] cur_y16;

  assign corners     = flags.known | (corner_bits & flags.unknown);
  assign on_boundary = flags.hit || (corners != CORNERS_NONE && corners != CORNERS_ALL);
  assign dir         = step_dir(corners);
  assign at_first    = (first_x == pos_x) && (first_y == pos_y);
  assign cur_x16     = IO_BITS'($signed(pos_x));
  assign cur_y16     = IO_BITS'($signed(pos_y));

  // Negative positions are never inside; an empty window never matches
  assign in_window = !pos_x[COORD_BITS-1] && !pos_y[COORD_BITS-1] &&
                     (CmpBits'(pos_x) < CmpBits'(map_width)) &&
                     (CmpBits'(pos_y) < CmpBits'(map_height));
  assign went_in_new = flags.went_in | (on_boundary & in_window);

  always_comb begin
    pos_x_next   = pos_x;
    pos_y_next   = pos_y;
    first_x_next = first_x;
    first_y_next = first_y;
    flags_next   = flags;
    result.kind        = EMIT_NONE;
    result.vertex_x    = '0;
    result.vertex_y    = '0;
    result.next_x      = cur_x16;
    result.next_y      = cur_y16;
    result.need_mask   = CORNERS_NONE;
    result.entered_map = flags.went_in;

    if (func == FUNC_START) begin
      pos_x_next         = COORD_BITS'($signed(begin_x));
      pos_y_next         = COORD_BITS'($signed(begin_y));
      flags_next.known   = CORNERS_NONE;
      flags_next.unknown = CORNERS_ALL;
      flags_next.hit     = 1'b0;
      flags_next.went_in = 1'b0;
      flags_next.closed  = 1'b0;
      result.next_x      = IO_BITS'($signed(pos_x_next));
      result.next_y      = IO_BITS'($signed(pos_y_next));
      result.need_mask   = CORNERS_ALL;
      result.entered_map = 1'b0;
    end else if (!flags.closed) begin
      flags_next.went_in = went_in_new;
      result.entered_map = went_in_new;
      if (on_boundary) begin
        result.vertex_x = cur_x16;
        result.vertex_y = cur_y16;
      end
      if (on_boundary && flags.hit && at_first) begin
        // back at the first vertex: contour done, position stays
        flags_next.closed = 1'b1;
        result.kind       = EMIT_CLOSED;
      end else begin
        if (on_boundary) begin
          flags_next.hit = 1'b1;
          if (!flags.hit) begin
            first_x_next = pos_x;
            first_y_next = pos_y;
            result.kind  = EMIT_MOVE;
          end else begin
            result.kind  = EMIT_LINE;
          end
        end
        case (dir)
          DIR_UP:  pos_y_next = pos_y - COORD_BITS'(1);
          DIR_DN:  pos_y_next = pos_y + COORD_BITS'(1);
          DIR_LT:  pos_x_next = pos_x - COORD_BITS'(1);
          default: pos_x_next = pos_x + COORD_BITS'(1);
        endcase
        flags_next.unknown = slide(dir, CORNERS_ALL) ^ CORNERS_ALL;
        flags_next.known   = slide(dir, corners);
        result.next_x      = IO_BITS'($signed(pos_x_next));
        result.next_y      = IO_BITS'($signed(pos_y_next));
        result.need_mask   = flags_next.unknown;
      end
    end
  end

endmodule

FILE: rtl/core/marching_squares_tracer.sv
// Throughput: one item per cycle while out_stall is not holding a result;
// the trace state feeds back through one step of combinational logic
// between the input register and the result register.
// Reset (rst, synchronous): window 640 x 480, position, hit and went_in cleared,
// all corners unknown, tracer idle (closed) until a start item arrives; both registers empty.
// Top level of the marching squares contour tracer.
`include "marching_squares_tracer_assert.svh"

module marching_squares_tracer import mst_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [WIN_BITS-1:0]        cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic signed [IO_BITS-1:0]  begin_x,
  input  logic signed [IO_BITS-1:0]  begin_y,
  input  logic [3:0]                 corner_bits,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 emit_kind,
  output logic signed [IO_BITS-1:0] vertex_x,
  output logic signed [IO_BITS-1:0] vertex_y,
  output logic signed [IO_BITS-1:0] next_x,
  output logic signed [IO_BITS-1:0] next_y,
  output logic [3:0]                 need_mask,
  output logic                       entered_map
);

  logic [WIN_BITS-1:0] map_width;
  logic [WIN_BITS-1:0] map_height;

  // input register
  logic                s1_valid;
  logic                s1_func;
  logic [IO_BITS-1:0]  s1_begin_x;
  logic [IO_BITS-1:0]  s1_begin_y;
  logic [3:0]          s1_corner;

  // trace state
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] first_x;
  logic [COORD_BITS-1:0] first_y;
  flags_t                flags;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;
  logic [COORD_BITS-1:0] first_x_next;
  logic [COORD_BITS-1:0] first_y_next;
  flags_t                flags_next;

  result_t step_result;
  result_t out_q;

  logic in_fire;
  logic s1_fire;

  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign s1_fire  = s1_valid && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= WIN_WIDTH_RESET;
      map_height <= WIN_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WIN_WIDTH:  map_width  <= cfg_data;
        CFG_WIN_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func    <= func;
      s1_begin_x <= begin_x;
      s1_begin_y <= begin_y;
      s1_corner  <= corner_bits;
    end
  end

  mst_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .func         (s1_func),
    .begin_x      (s1_begin_x),
    .begin_y      (s1_begin_y),
    .corner_bits  (s1_corner),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .first_x      (first_x),
    .first_y      (first_y),
    .flags        (flags),
    .map_width    (map_width),
    .map_height   (map_height),
    .pos_x_next   (pos_x_next),
    .pos_y_next   (pos_y_next),
    .first_x_next (first_x_next),
    .first_y_next (first_y_next),
    .flags_next   (flags_next),
    .result       (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      first_x       <= '0;
      first_y       <= '0;
      flags.known   <= CORNERS_NONE;
      flags.unknown <= CORNERS_ALL;
      flags.hit     <= 1'b0;
      flags.went_in <= 1'b0;
      flags.closed  <= 1'b1;
    end else if (s1_fire) begin
      pos_x   <= pos_x_next;
      pos_y   <= pos_y_next;
      first_x <= first_x_next;
      first_y <= first_y_next;
      flags   <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_q <= step_result;
    end
  end

  assign emit_kind   = out_q.kind;
  assign vertex_x    = out_q.vertex_x;
  assign vertex_y    = out_q.vertex_y;
  assign next_x      = out_q.next_x;
  assign next_y      = out_q.next_y;
  assign need_mask   = out_q.need_mask;
  assign entered_map = out_q.entered_map;

  `MST_ASSERT_SAME(a_closed_result_shape,
    out_valid && (out_q.kind == EMIT_CLOSED),
    (out_q.need_mask == CORNERS_NONE) && (out_q.vertex_x == out_q.next_x) &&
    (out_q.vertex_y == out_q.next_y),
    "closed result must stay in place with no corners needed")
  `MST_ASSERT_NEXT(a_close_goes_idle,
    s1_fire && (step_result.kind == EMIT_CLOSED),
    flags.closed,
    "tracer not idle after closing the contour")
  `MST_ASSERT_NEXT(a_start_arms_trace,
    s1_fire && (s1_func == FUNC_START),
    !flags.closed && !flags.hit && (flags.unknown == CORNERS_ALL),
    "start item did not arm a fresh trace")
  `MST_ASSERT_SAME(a_unknown_shape,
    1'b1,
    (flags.unknown == CORNERS_ALL) || ($countones(flags.unknown) == 2),
    "unknown corner mask must be all corners or one side")

endmodule

FILE: tb/sv/tb_marching_squares_tracer.sv
// Self-checking testbench for the marching squares contour tracer.
`timescale 1ns / 1ps

module tb_marching_squares_tracer;
  import mst_pkg::*;

  typedef enum {ROW_ITEM, ROW_CFG} row_op_t;
  typedef enum {BLOB_DISC, BLOB_BOX, BLOB_SPECKLE} blob_t;

  typedef struct {
    row_op_t              op;
    logic                 fn;
    logic [IO_BITS-1:0]   bx;
    logic [IO_BITS-1:0]   by;
    logic [3:0]           cb;
    bit                   typed;
    result_t              res;
    logic                 cfg_idx;
    logic [WIN_BITS-1:0]  cfg_val;
  } stim_row_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic                       cfg_index = CFG_WIN_WIDTH;
  logic [WIN_BITS-1:0]        cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       func = FUNC_START;
  logic signed [IO_BITS-1:0]  begin_x = '0;
  logic signed [IO_BITS-1:0]  begin_y = '0;
  logic [3:0]                 corner_bits = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 emit_kind;
  logic signed [IO_BITS-1:0]  vertex_x;
  logic signed [IO_BITS-1:0]  vertex_y;
  logic signed [IO_BITS-1:0]  next_x;
  logic signed [IO_BITS-1:0]  next_y;
  logic [3:0]                 need_mask;
  logic                       entered_map;

  marching_squares_tracer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .begin_x(begin_x), .begin_y(begin_y), .corner_bits(corner_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .emit_kind(emit_kind), .vertex_x(vertex_x), .vertex_y(vertex_y),
    .next_x(next_x), .next_y(next_y), .need_mask(need_mask), .entered_map(entered_map)
  );

  // Tracer state as predicted
  logic [IO_BITS-1:0]  at_x, at_y, origin_x, origin_y;
  logic [3:0]          known_c, open_c;
  logic                on_edge, been_inside, idle_trace;
  logic [WIN_BITS-1:0] win_w, win_h;

  result_t   pending_results[$];
  stim_row_t plan[$];
  int        mismatches = 0;
  int        useful_items = 0;
  int        send_pct = 0;
  int        stall_pct = 0;

  // Current test image
  blob_t       blob_kind;
  int          blob_x, blob_y, blob_r, blob_w, blob_h;
  logic [63:0] speckle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function automatic result_t trace_step(logic fn, logic [IO_BITS-1:0] bx,
                                         logic [IO_BITS-1:0] by, logic [3:0] cb);
    result_t    r;
    logic [3:0] corners;
    dir_t       d;
    r = '0;
    if (fn == FUNC_START) begin
      at_x = bx;
      at_y = by;
      known_c = CORNERS_NONE;
      open_c = CORNERS_ALL;
      on_edge = 1'b0;
      been_inside = 1'b0;
      idle_trace = 1'b0;
      r.kind = EMIT_NONE;
      r.next_x = at_x;
      r.next_y = at_y;
      r.need_mask = CORNERS_ALL;
      return r;
    end
    if (idle_trace) begin
      r.kind = EMIT_NONE;
      r.next_x = at_x;
      r.next_y = at_y;
      r.need_mask = CORNERS_NONE;
      r.entered_map = been_inside;
      return r;
    end
    corners = known_c | (cb & open_c);
    r.kind = EMIT_NONE;
    if (on_edge || (corners != CORNERS_NONE && corners != CORNERS_ALL)) begin
      if (!at_x[IO_BITS-1] && at_x < win_w && !at_y[IO_BITS-1] && at_y < win_h)
        been_inside = 1'b1;
      r.vertex_x = at_x;
      r.vertex_y = at_y;
      if (!on_edge) begin
        origin_x = at_x;
        origin_y = at_y;
        r.kind = EMIT_MOVE;
      end else if (origin_x == at_x && origin_y == at_y) begin
        idle_trace = 1'b1;
        r.kind = EMIT_CLOSED;
        r.next_x = at_x;
        r.next_y = at_y;
        r.need_mask = CORNERS_NONE;
        r.entered_map = been_inside;
        return r;
      end else begin
        r.kind = EMIT_LINE;
      end
      on_edge = 1'b1;
    end
    case (corners)
      4'd8, 4'd9, 4'd10, 4'd11: d = DIR_UP;
      4'd2, 4'd3, 4'd6, 4'd7:   d = DIR_LT;
      4'd1, 4'd5, 4'd13:        d = DIR_DN;
      default:                  d = DIR_RT;
    endcase
    // the side facing the move is new, the opposite side carries over
    case (d)
      DIR_UP: begin
        at_y = at_y - 1'b1;
        known_c = (corners & CORNERS_TOP) >> 2;
        open_c = CORNERS_TOP;
      end
      DIR_DN: begin
        at_y = at_y + 1'b1;
        known_c = (corners & CORNERS_BOTTOM) << 2;
        open_c = CORNERS_BOTTOM;
      end
      DIR_LT: begin
        at_x = at_x - 1'b1;
        known_c = (corners & CORNERS_LEFT) >> 1;
        open_c = CORNERS_LEFT;
      end
      default: begin
        at_x = at_x + 1'b1;
        known_c = (corners & CORNERS_RIGHT) << 1;
        open_c = CORNERS_RIGHT;
      end
    endcase
    r.next_x = at_x;
    r.next_y = at_y;
    r.need_mask = open_c;
    r.entered_map = been_inside;
    return r;
  endfunction

  function automatic result_t mk_res(emit_t k, logic [IO_BITS-1:0] vx, logic [IO_BITS-1:0] vy,
                                     logic [IO_BITS-1:0] nx, logic [IO_BITS-1:0] ny,
                                     logic [3:0] need, logic ent);
    result_t r;
    r.kind = k;
    r.vertex_x = vx;
    r.vertex_y = vy;
    r.next_x = nx;
    r.next_y = ny;
    r.need_mask = need;
    r.entered_map = ent;
    return r;
  endfunction

  function automatic void add_item(logic fn, logic [IO_BITS-1:0] bx, logic [IO_BITS-1:0] by,
                                   logic [3:0] cb);
    stim_row_t row;
    row = '{op: ROW_ITEM, fn: fn, bx: bx, by: by, cb: cb, typed: 1'b0, res: '0,
            cfg_idx: CFG_WIN_WIDTH, cfg_val: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_typed(logic fn, logic [IO_BITS-1:0] bx, logic [IO_BITS-1:0] by,
                                    logic [3:0] cb, result_t res);
    stim_row_t row;
    row = '{op: ROW_ITEM, fn: fn, bx: bx, by: by, cb: cb, typed: 1'b1, res: res,
            cfg_idx: CFG_WIN_WIDTH, cfg_val: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(logic idx, logic [WIN_BITS-1:0] val);
    stim_row_t row;
    row = '{op: ROW_CFG, fn: FUNC_START, bx: '0, by: '0, cb: '0, typed: 1'b0, res: '0,
            cfg_idx: idx, cfg_val: val};
    plan.push_back(row);
  endfunction

  function automatic bit pixel_on(int px, int py);
    longint dx, dy;
    dx = px - blob_x;
    dy = py - blob_y;
    case (blob_kind)
      BLOB_DISC: return dx * dx + dy * dy <= blob_r * blob_r;
      BLOB_BOX:  return dx >= 0 && dx < blob_w && dy >= 0 && dy < blob_h;
      default:   return dx >= 0 && dx < 8 && dy >= 0 && dy < 8 && speckle[dy * 8 + dx];
    endcase
  endfunction

  // Image anchor near the origin, near the far window edge, near the wrap, or anywhere
  function automatic int anchor(int extent);
    case ($urandom_range(0, 7))
      0, 1, 2: return int'($urandom_range(0, 20)) - 10;
      3, 4, 5: return extent + int'($urandom_range(0, 20)) - 10;
      6:       return 32767 - int'($urandom_range(0, 12));
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic note_mismatch(string what, logic [IO_BITS-1:0] got, logic [IO_BITS-1:0] want);
    $display("%0t MISMATCH %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(logic fn, logic [IO_BITS-1:0] bx, logic [IO_BITS-1:0] by,
                           logic [3:0] cb, bit typed, result_t typed_res);
    int      gap;
    result_t r;
    gap = 0;
    while (send_pct > 0 && $urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    begin_x <= bx;
    begin_y <= by;
    corner_bits <= cb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fn == FUNC_START || !idle_trace) useful_items++;
    r = trace_step(fn, bx, by, cb);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [WIN_BITS-1:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_WIN_WIDTH) win_w = val;
    else win_h = val;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_trace();
    int         sx, sy, x, y, n, extra;
    logic [3:0] cb;
    blob_kind = blob_t'($urandom_range(0, 2));
    blob_r = $urandom_range(1, 5);
    blob_w = $urandom_range(1, 5);
    blob_h = $urandom_range(1, 5);
    speckle = {$urandom, $urandom};
    blob_x = anchor(int'(win_w));
    blob_y = anchor(int'(win_h));
    sx = blob_x - int'($urandom_range(1, 4)) - (blob_kind == BLOB_DISC ? blob_r : 0);
    case (blob_kind)
      BLOB_DISC: sy = blob_y;
      BLOB_BOX:  sy = blob_y + int'($urandom_range(0, blob_h - 1));
      default:   sy = blob_y + int'($urandom_range(0, 7));
    endcase
    send_item(FUNC_START, IO_BITS'(sx), IO_BITS'(sy), 4'($urandom), 1'b0, '0);
    for (n = 0; n < 90 && !idle_trace; n++) begin
      x = int'($signed(at_x));
      y = int'($signed(at_y));
      cb = {pixel_on(x, y), pixel_on(x + 1, y), pixel_on(x, y + 1), pixel_on(x + 1, y + 1)};
      // junk on corners already known must be ignored
      if ($urandom_range(99) < 30) cb = (cb & open_c) | (4'($urandom) & ~open_c);
      send_item(FUNC_SAMPLE, 16'($urandom), 16'($urandom), cb, 1'b0, '0);
    end
    if (idle_trace && $urandom_range(9) == 0) begin
      extra = $urandom_range(1, 2);
      repeat (extra) send_item(FUNC_SAMPLE, 16'($urandom), 16'($urandom), 4'($urandom), 1'b0, '0);
    end
  endtask

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = pending_results.pop_front();
        if (emit_kind !== want.kind) note_mismatch("emit_kind", emit_kind, want.kind);
        if (vertex_x !== want.vertex_x) note_mismatch("vertex_x", vertex_x, want.vertex_x);
        if (vertex_y !== want.vertex_y) note_mismatch("vertex_y", vertex_y, want.vertex_y);
        if (next_x !== want.next_x) note_mismatch("next_x", next_x, want.next_x);
        if (next_y !== want.next_y) note_mismatch("next_y", next_y, want.next_y);
        if (need_mask !== want.need_mask) note_mismatch("need_mask", need_mask, want.need_mask);
        if (entered_map !== want.entered_map)
          note_mismatch("entered_map", entered_map, want.entered_map);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= stall_pct > 0 && $urandom_range(99) < stall_pct;
  end

  initial begin
    int        ph, goal, burst, k;
    int        phase_w[8];
    int        phase_h[8];
    stim_row_t row;

    at_x = '0; at_y = '0; origin_x = '0; origin_y = '0;
    known_c = CORNERS_NONE;
    open_c = CORNERS_ALL;
    on_edge = 1'b0;
    been_inside = 1'b0;
    idle_trace = 1'b1;
    win_w = WIN_WIDTH_RESET;
    win_h = WIN_HEIGHT_RESET;

    // idle after reset: samples are ignored
    add_typed(FUNC_SAMPLE, 16'h0, 16'h0, 4'hF,
              mk_res(EMIT_NONE, 16'h0, 16'h0, 16'h0, 16'h0, CORNERS_NONE, 1'b0));
    // loop around one inside pixel at (5,5), closes on the fifth square
    add_typed(FUNC_START, 16'd4, 16'd4, 4'h0,
              mk_res(EMIT_NONE, 16'h0, 16'h0, 16'd4, 16'd4, CORNERS_ALL, 1'b0));
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h1);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'hC);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'hA);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h3);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h5);
    add_typed(FUNC_SAMPLE, 16'h0, 16'h0, 4'h6,
              mk_res(EMIT_NONE, 16'h0, 16'h0, 16'd4, 16'd4, CORNERS_NONE, 1'b1));
    // positive extreme, walk wraps in x then y
    add_typed(FUNC_START, 16'h7FFF, 16'h7FFF, 4'hF,
              mk_res(EMIT_NONE, 16'h0, 16'h0, 16'h7FFF, 16'h7FFF, CORNERS_ALL, 1'b0));
    add_item(FUNC_SAMPLE, 16'hFFFF, 16'hFFFF, 4'h0);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h1);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h4);
    // negative extreme, restart in the middle of an open trace
    add_typed(FUNC_START, 16'h8000, 16'h8000, 4'h0,
              mk_res(EMIT_NONE, 16'h0, 16'h0, 16'h8000, 16'h8000, CORNERS_ALL, 1'b0));
    add_item(FUNC_SAMPLE, 16'hFFFF, 16'hFFFF, 4'hF);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h8);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h7);
    // zero-width window, then zero-height window: origin never counts as inside
    add_cfg(CFG_WIN_WIDTH, 15'd0);
    add_item(FUNC_START, 16'h0, 16'h0, 4'h0);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h1);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h4);
    add_cfg(CFG_WIN_WIDTH, WIN_WIDTH_RESET);
    add_cfg(CFG_WIN_HEIGHT, 15'd0);
    add_item(FUNC_START, 16'h0, 16'h0, 4'h0);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h1);
    add_cfg(CFG_WIN_HEIGHT, WIN_HEIGHT_RESET);
    add_item(FUNC_START, 16'h0, 16'h0, 4'h0);
    add_item(FUNC_SAMPLE, 16'h0, 16'h0, 4'h1);

    phase_w = '{640, 1, 16384, 0, 32767, 20, 0, 16384};
    phase_h = '{480, 1, 16384, 480, 1, 0, 0, 1};
    phase_w[6] = $urandom_range(1, 64);
    phase_h[6] = $urandom_range(1, 64);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.op == ROW_CFG) write_reg(row.cfg_idx, row.cfg_val);
      else send_item(row.fn, row.bx, row.by, row.cb, row.typed, row.res);
    end

    for (ph = 0; ph < 8; ph++) begin
      write_reg(CFG_WIN_WIDTH, WIN_BITS'(phase_w[ph]));
      write_reg(CFG_WIN_HEIGHT, WIN_BITS'(phase_h[ph]));
      case (ph % 4)
        0:       begin send_pct = 0;  stall_pct = 0;  end
        1:       begin send_pct = 84; stall_pct = 0;  end
        2:       begin send_pct = 0;  stall_pct = 84; end
        default: begin send_pct = 6;  stall_pct = 6;  end
      endcase
      goal = useful_items + 60;
      while (useful_items < goal) begin
        if ($urandom_range(99) < 70) begin
          run_trace();
        end else begin
          // random items: stray starts, samples on whatever trace is open
          burst = $urandom_range(1, 6);
          for (k = 0; k < burst; k++)
            send_item(1'($urandom), 16'($urandom), 16'($urandom), 4'($urandom), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
